### src/pps_pkg.sv
// Shared types, constants and helper functions for the pure-pursuit steering block.
// No dependencies; every other file in src imports this package.
package pps_pkg;

  // Structural sizes
  localparam int CORDIC_STEPS   = 16;
  localparam int INTEGRAL_WIDTH = 48;
  localparam int ITER_W         = $clog2(CORDIC_STEPS);

  // Field widths
  localparam int POS_W      = 32;
  localparam int HEAD_W     = 16;
  localparam int GAIN_W     = 16;
  localparam int LEAD_W     = 31;
  localparam int OUT_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  // CORDIC datapath
  localparam int GUARD_BITS = 8;
  localparam int DELTA_W    = POS_W + 1;
  localparam int CW         = 44;
  localparam int Z_W        = 34;
  localparam int BEAR_SHIFT = 17;
  localparam int BEAR_W     = Z_W - BEAR_SHIFT;
  localparam int BEAR_ROUND = 65536;
  localparam int DIFF_W     = 19;

  // Magnitude scaling by 1/K, split in two partial products
  localparam int INV_GAIN_W   = 20;
  localparam int INV_GAIN     = 636751;
  localparam int MAG_SHIFT    = 20 + GUARD_BITS;
  localparam int MAG_SPLIT    = 22;
  localparam int MAG_LO_SHIFT = MAG_SHIFT - MAG_SPLIT;
  localparam int LO_W         = MAG_SPLIT + INV_GAIN_W + 1;
  localparam int SUM_W        = 44;
  localparam int MAG_W        = 34;
  localparam longint MAG_ROUND = 64'd1 << (MAG_SHIFT - 1);

  // Shared multiplier and accumulators
  localparam int MUL_A_W    = INV_GAIN_W;
  localparam int MUL_B_W    = 42;
  localparam int PROD_W     = MUL_A_W + 1 + MUL_B_W;
  localparam int ACC_W      = 50;
  localparam int FRAC_I     = 14;
  localparam int VEL_ROUND  = 8192;
  localparam int TURN_SHIFT = 11;
  localparam int TURN_ROUND = 1024;
  localparam int QW         = INTEGRAL_WIDTH - FRAC_I;
  localparam int QCW        = (QW > MUL_B_W) ? QW : MUL_B_W;
  localparam int Q_LIMIT_SH = 40;

  // Angle constants
  localparam longint PI_Q30     = 64'd3373259426;
  localparam int     PI_Q13     = 25736;
  localparam int     TWO_PI_Q13 = 51472;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_SELECT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADING_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAD_DISTANCE = 3'd4;

  // Reset values of the configuration registers
  localparam logic [GAIN_W-1:0] PROP_GAIN_RST     = 16'd3277;
  localparam logic [GAIN_W-1:0] INTEGRAL_GAIN_RST = 16'd131;
  localparam logic [GAIN_W-1:0] HEADING_GAIN_RST  = 16'd8192;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MAG_LO,
    ST_MAG_HI,
    ST_MAG,
    ST_ERR,
    ST_INT,
    ST_INT_R,
    ST_INT_Q,
    ST_HEAD,
    ST_OUT
  } pps_state_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_MAG_LO,
    MUL_MAG_HI,
    MUL_PROP,
    MUL_INT_R,
    MUL_INT_Q,
    MUL_HEAD
  } pps_mul_sel_t;

  typedef struct packed {
    logic              mode_select;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integral_gain;
    logic [GAIN_W-1:0] heading_gain;
    logic [LEAD_W-1:0] lead_distance;
  } pps_cfg_t;

  typedef struct packed {
    logic              load;
    logic              cordic;
    logic [ITER_W-1:0] iter;
    pps_mul_sel_t      mul_sel;
    logic              acc_load;
    logic              acc_add;
    logic              mag_calc;
    logic              err_calc;
    logic              int_upd;
    logic              vel_calc;
    logic              out_load;
  } pps_cmd_t;

  // Elementary rotation angles atan(2^-i), Q2.30
  function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [Z_W-1:0] a;
    unique case (idx)
      5'd0:  a = 34'sh03243F6A8;
      5'd1:  a = 34'sh01DAC6705;
      5'd2:  a = 34'sh00FADBAFC;
      5'd3:  a = 34'sh007F56EA6;
      5'd4:  a = 34'sh003FEAB76;
      5'd5:  a = 34'sh001FFD55B;
      5'd6:  a = 34'sh000FFFAAA;
      5'd7:  a = 34'sh0007FFF55;
      5'd8:  a = 34'sh0003FFFEA;
      5'd9:  a = 34'sh0001FFFFD;
      5'd10: a = 34'sh0000FFFFF;
      5'd11: a = 34'sh00007FFFF;
      5'd12: a = 34'sh00003FFFF;
      5'd13: a = 34'sh00001FFFF;
      5'd14: a = 34'sh00000FFFF;
      5'd15: a = 34'sh000007FFF;
      5'd16: a = 34'sh000003FFF;
      5'd17: a = 34'sh000001FFF;
      5'd18: a = 34'sh000000FFF;
      5'd19: a = 34'sh0000007FF;
      5'd20: a = 34'sh0000003FF;
      5'd21: a = 34'sh0000001FF;
      5'd22: a = 34'sh0000000FF;
      5'd23: a = 34'sh00000007F;
      5'd24: a = 34'sh00000003F;
      5'd25: a = 34'sh00000001F;
      5'd26: a = 34'sh00000000F;
      5'd27: a = 34'sh000000007;
      5'd28: a = 34'sh000000003;
      5'd29: a = 34'sh000000001;
      5'd30: a = 34'sh000000000;
      5'd31: a = 34'sh000000000;
    endcase
    return a;
  endfunction

  // Clamp a wide signed value to the 32-bit signed range
  function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [OUT_W-1:0] s;
    if (v > 64'sd2147483647) begin
      s = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      s = 32'sh80000000;
    end else begin
      s = v[OUT_W-1:0];
    end
    return s;
  endfunction

endpackage

### src/pure_pursuit_pi_steering_top.sv
// Top level of the pure-pursuit steering block: configuration registers,
// sequencer and datapath. Depends on pps_pkg, pps_ctrl and pps_dp.
//
// Takes one pose/goal request at a time and returns one command (linear
// velocity, turn rate, distance error) per request. A request is accepted
// when in_valid is high and in_stall is low; in_stall stays high while the
// request is worked, so no new request is taken until it is done. A request
// runs through the idle step that takes it, the vectoring loop, which does
// one CORDIC micro-rotation per cycle, then eight steps built around a single
// 20x42 multiplier (two partial products for the 1/K magnitude scaling, the
// proportional, integral and turn products) and the output load.
// The result sits in an output register until out_stall is low, so the next
// request is taken while a result waits; when a result is still stalled at
// the end of the following request, that request holds in its final step.
// In pure-pursuit mode the velocity integral persists across requests and
// saturates at its width; in proportional mode it is frozen. Write
// configuration only while no request is in flight; cfg_ready is always high
// and an index past the last register is dropped.
module pure_pursuit_pi_steering_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [pps_pkg::POS_W-1:0]      in_cur_x,
  input  logic signed [pps_pkg::POS_W-1:0]      in_cur_y,
  input  logic signed [pps_pkg::HEAD_W-1:0]     in_cur_heading,
  input  logic signed [pps_pkg::POS_W-1:0]      in_goal_x,
  input  logic signed [pps_pkg::POS_W-1:0]      in_goal_y,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [pps_pkg::OUT_W-1:0]      out_lin_velocity,
  output logic signed [pps_pkg::OUT_W-1:0]      out_turn_rate,
  output logic signed [pps_pkg::OUT_W-1:0]      out_distance_error,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pps_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pps_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import pps_pkg::*;

  pps_cfg_t cfg_r;
  pps_cmd_t cmd;

  // Configuration writes always taken; user must keep block idle when they come
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode_select   <= 1'b0;
      cfg_r.prop_gain     <= PROP_GAIN_RST;
      cfg_r.integral_gain <= INTEGRAL_GAIN_RST;
      cfg_r.heading_gain  <= HEADING_GAIN_RST;
      cfg_r.lead_distance <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE_SELECT:   cfg_r.mode_select   <= cfg_data[0];
        CFG_PROP_GAIN:     cfg_r.prop_gain     <= cfg_data[GAIN_W-1:0];
        CFG_INTEGRAL_GAIN: cfg_r.integral_gain <= cfg_data[GAIN_W-1:0];
        CFG_HEADING_GAIN:  cfg_r.heading_gain  <= cfg_data[GAIN_W-1:0];
        CFG_LEAD_DISTANCE: cfg_r.lead_distance <= cfg_data[LEAD_W-1:0];
        default:           cfg_r <= cfg_r;  // drop writes past the last register
      endcase
    end
  end

  // Sequencer: owns the handshakes and steps the datapath
  pps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath: CORDIC, shared multiplier, integral, result registers
  pps_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd            (cmd),
    .cur_x          (in_cur_x),
    .cur_y          (in_cur_y),
    .cur_heading    (in_cur_heading),
    .goal_x         (in_goal_x),
    .goal_y         (in_goal_y),
    .lin_velocity   (out_lin_velocity),
    .turn_rate      (out_turn_rate),
    .distance_error (out_distance_error)
  );

endmodule

### src/pps_ctrl.sv
// Sequencer for the pure-pursuit steering block: walks one request through
// the CORDIC and multiply steps. Depends on pps_pkg.
module pps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output pps_pkg::pps_cmd_t  cmd
);
  import pps_pkg::*;

  pps_state_t        state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              iter_last;
  logic              out_free;

  assign iter_last = (iter_r == ITER_W'(CORDIC_STEPS - 1));
  assign out_free  = !out_valid_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    unique case (state_r)
      ST_IDLE: begin
        iter_nxt = '0;
        if (in_valid) state_nxt = ST_CORDIC;
      end
      ST_CORDIC: begin
        iter_nxt = iter_r + 1'b1;
        if (iter_last) state_nxt = ST_MAG_LO;
      end
      ST_MAG_LO: state_nxt = ST_MAG_HI;
      ST_MAG_HI: state_nxt = ST_MAG;
      ST_MAG:    state_nxt = ST_ERR;
      ST_ERR:    state_nxt = ST_INT;
      ST_INT:    state_nxt = ST_INT_R;
      ST_INT_R:  state_nxt = ST_INT_Q;
      ST_INT_Q:  state_nxt = ST_HEAD;
      ST_HEAD:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_NONE;
    cmd.iter    = iter_r;
    unique case (state_r)
      ST_IDLE:   cmd.load = in_valid;
      ST_CORDIC: cmd.cordic = 1'b1;
      ST_MAG_LO: cmd.mul_sel = MUL_MAG_LO;
      ST_MAG_HI: begin
        cmd.acc_load = 1'b1;
        cmd.mul_sel  = MUL_MAG_HI;
      end
      ST_MAG:    cmd.mag_calc = 1'b1;
      ST_ERR:    cmd.err_calc = 1'b1;
      ST_INT: begin
        cmd.int_upd = 1'b1;
        cmd.mul_sel = MUL_PROP;
      end
      ST_INT_R: begin
        cmd.acc_load = 1'b1;
        cmd.mul_sel  = MUL_INT_R;
      end
      ST_INT_Q: begin
        cmd.acc_add = 1'b1;
        cmd.mul_sel = MUL_INT_Q;
      end
      ST_HEAD: begin
        cmd.vel_calc = 1'b1;
        cmd.mul_sel  = MUL_HEAD;
      end
      ST_OUT:    cmd.out_load = out_free;
      default:   cmd.mul_sel = MUL_NONE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // A new request always starts the rotation loop at step zero
  a_start_iter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid) |=> (state_r == ST_CORDIC && iter_r == '0))
    else $error("rotation loop did not start at step zero");

  // The loop ends after its last step and moves on to the first magnitude step
  a_loop_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORDIC && iter_last) |=> (state_r == ST_MAG_LO))
    else $error("rotation loop did not end after the last step");

  // A result appears only from the final step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside the output step");

endmodule

### src/pps_dp.sv
// Datapath of the pure-pursuit steering block: CORDIC vectoring unit, shared
// multiplier, PI integral and output registers. Depends on pps_pkg.
module pps_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pps_pkg::pps_cfg_t                   cfg,
  input  pps_pkg::pps_cmd_t                   cmd,
  input  logic signed [pps_pkg::POS_W-1:0]    cur_x,
  input  logic signed [pps_pkg::POS_W-1:0]    cur_y,
  input  logic signed [pps_pkg::HEAD_W-1:0]   cur_heading,
  input  logic signed [pps_pkg::POS_W-1:0]    goal_x,
  input  logic signed [pps_pkg::POS_W-1:0]    goal_y,
  output logic signed [pps_pkg::OUT_W-1:0]    lin_velocity,
  output logic signed [pps_pkg::OUT_W-1:0]    turn_rate,
  output logic signed [pps_pkg::OUT_W-1:0]    distance_error
);
  import pps_pkg::*;

  localparam int ISUM_W = INTEGRAL_WIDTH + 1;
  localparam logic signed [QCW-1:0] Q_MAX = QCW'(1) <<< Q_LIMIT_SH;
  localparam logic signed [QCW-1:0] Q_MIN = -Q_MAX;

  // Registers
  logic signed [CW-1:0]             x_r, y_r;
  logic signed [Z_W-1:0]            z_r;
  logic signed [HEAD_W-1:0]         heading_r;
  logic                             zero_r;
  logic signed [PROD_W-1:0]         prod_r;
  logic signed [ACC_W-1:0]          acc_r;
  logic [MAG_W-1:0]                 mag_r;
  logic signed [BEAR_W-1:0]         bearing_r;
  logic signed [OUT_W-1:0]          err_r;
  logic signed [DIFF_W-1:0]         diff_r;
  logic signed [INTEGRAL_WIDTH-1:0] int_r, int_nxt;
  logic signed [OUT_W-1:0]          vel_r;
  logic signed [OUT_W-1:0]          lin_velocity_r, turn_rate_r, distance_error_r;

  // Load and rotation
  logic signed [DELTA_W-1:0] dx, dy;
  logic signed [CW-1:0]      x0;
  logic signed [CW-1:0]      xs, ys;
  logic signed [Z_W-1:0]     step_ang;

  assign dx       = DELTA_W'(goal_x) - DELTA_W'(cur_x);
  assign dy       = DELTA_W'(goal_y) - DELTA_W'(cur_y);
  assign x0       = CW'(dx) <<< GUARD_BITS;
  assign xs       = x_r >>> cmd.iter;
  assign ys       = y_r >>> cmd.iter;
  assign step_ang = atan_q30(5'(cmd.iter));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      heading_r <= cur_heading;
      zero_r    <= (dx == '0) && (dy == '0);
      if (dx < 0) begin
        x_r <= -x0;
        y_r <= -(CW'(dy) <<< GUARD_BITS);
        z_r <= (dy >= 0) ? Z_W'(PI_Q30) : -Z_W'(PI_Q30);
      end else begin
        x_r <= x0;
        y_r <= CW'(dy) <<< GUARD_BITS;
        z_r <= '0;
      end
    end else if (cmd.cordic) begin
      if (!y_r[CW-1]) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + step_ang;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - step_ang;
      end
    end
  end

  // Shared multiplier: unsigned coefficient times signed operand
  logic [MUL_A_W-1:0]         mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [QW-1:0]       q;
  logic signed [QCW-1:0]      q_ext, q_clip;

  assign q     = int_r[INTEGRAL_WIDTH-1:FRAC_I];
  assign q_ext = QCW'(q);

  always_comb begin
    if (q_ext > Q_MAX) begin
      q_clip = Q_MAX;
    end else if (q_ext < Q_MIN) begin
      q_clip = Q_MIN;
    end else begin
      q_clip = q_ext;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      MUL_MAG_LO: begin
        mul_a = MUL_A_W'(INV_GAIN);
        mul_b = MUL_B_W'(x_r[MAG_SPLIT-1:0]);
      end
      MUL_MAG_HI: begin
        mul_a = MUL_A_W'(INV_GAIN);
        mul_b = MUL_B_W'(x_r[CW-1:MAG_SPLIT]);
      end
      MUL_PROP: begin
        mul_a = MUL_A_W'(cfg.prop_gain);
        mul_b = MUL_B_W'(err_r);
      end
      MUL_INT_R: begin
        mul_a = cfg.mode_select ? '0 : MUL_A_W'(cfg.integral_gain);
        mul_b = MUL_B_W'(int_r[FRAC_I-1:0]);
      end
      MUL_INT_Q: begin
        mul_a = cfg.mode_select ? '0 : MUL_A_W'(cfg.integral_gain);
        mul_b = q_clip[MUL_B_W-1:0];
      end
      MUL_HEAD: begin
        mul_a = MUL_A_W'(cfg.heading_gain);
        mul_b = MUL_B_W'(diff_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = $signed({1'b0, mul_a}) * mul_b;

  // Magnitude and bearing
  logic [LO_W-1:0]        lo_rnd;
  logic [SUM_W-1:0]       mag_sum;
  logic signed [Z_W-1:0]  z_rnd;

  assign lo_rnd  = LO_W'(acc_r[LO_W-2:0]) + LO_W'(MAG_ROUND);
  assign mag_sum = SUM_W'(prod_r[SUM_W-2:0]) + SUM_W'(lo_rnd[LO_W-1:MAG_SPLIT]);
  assign z_rnd   = z_r + Z_W'(BEAR_ROUND);

  // Distance error and wrapped angle
  logic signed [MAG_W+1:0]  mag_lead;
  logic signed [DIFF_W-1:0] diff0;

  assign mag_lead = (MAG_W+2)'(mag_r) - (MAG_W+2)'(cfg.lead_distance);
  assign diff0    = DIFF_W'(bearing_r) - DIFF_W'(heading_r);

  // Velocity and turn rounding
  logic signed [ACC_W-1:0]             acc_rnd;
  logic signed [ACC_W-FRAC_I-1:0]      acc_sh;
  logic signed [PROD_W-1:0]            turn_rnd;
  logic signed [PROD_W-TURN_SHIFT-1:0] turn_sh;

  assign acc_rnd  = acc_r + ACC_W'(VEL_ROUND);
  assign acc_sh   = acc_rnd[ACC_W-1:FRAC_I];
  assign turn_rnd = prod_r + PROD_W'(TURN_ROUND);
  assign turn_sh  = turn_rnd[PROD_W-1:TURN_SHIFT];

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != MUL_NONE) prod_r <= mul_p;
    if (cmd.acc_load) begin
      acc_r <= ACC_W'(prod_r);
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
    if (cmd.mag_calc) begin
      mag_r     <= zero_r ? '0 : mag_sum[MAG_W+MAG_LO_SHIFT-1:MAG_LO_SHIFT];
      bearing_r <= zero_r ? '0 : z_rnd[Z_W-1:BEAR_SHIFT];
    end
    if (cmd.err_calc) begin
      err_r <= cfg.mode_select ? sat32(64'(mag_r)) : sat32(64'(mag_lead));
      if (diff0 > DIFF_W'(PI_Q13)) begin
        diff_r <= diff0 - DIFF_W'(TWO_PI_Q13);
      end else if (diff0 < -DIFF_W'(PI_Q13)) begin
        diff_r <= diff0 + DIFF_W'(TWO_PI_Q13);
      end else begin
        diff_r <= diff0;
      end
    end
    if (cmd.vel_calc) vel_r <= sat32(64'(prod_r) + 64'(acc_sh));
    if (cmd.out_load) begin
      lin_velocity_r   <= vel_r;
      turn_rate_r      <= sat32(64'(turn_sh));
      distance_error_r <= err_r;
    end
  end

  // Saturating integral: overflow shows as disagreeing top bits of the sum
  logic signed [ISUM_W-1:0] int_sum;

  assign int_sum = ISUM_W'(int_r) + ISUM_W'(err_r);

  always_comb begin
    int_nxt = int_r;
    if (cmd.int_upd && !cfg.mode_select) begin
      if (int_sum[ISUM_W-1] != int_sum[ISUM_W-2]) begin
        int_nxt = int_sum[ISUM_W-1] ? {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}}
                                    : {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
      end else begin
        int_nxt = int_sum[INTEGRAL_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_r <= '0;
    end else begin
      int_r <= int_nxt;
    end
  end

  assign lin_velocity   = lin_velocity_r;
  assign turn_rate      = turn_rate_r;
  assign distance_error = distance_error_r;

  // The vectoring x component never goes negative
  a_x_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load || cmd.cordic) |=> !x_r[CW-1])
    else $error("CORDIC x component went negative");

  // Proportional mode leaves the integral alone
  a_int_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.int_upd && cfg.mode_select) |=> $stable(int_r))
    else $error("integral changed in proportional mode");

  // Raw distance error is never negative
  a_err_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.err_calc && cfg.mode_select) |=> !err_r[OUT_W-1])
    else $error("raw distance error went negative");

endmodule

### sim/pps_checker.sv
// Scoreboard for the pure-pursuit steering block: watches the request, result and
// register-write channels, predicts every command and compares it field by field.
// Depends on pps_pkg for port widths, register indexes and register reset values.
module pps_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic signed [pps_pkg::POS_W-1:0]  in_cur_x,
  input  logic signed [pps_pkg::POS_W-1:0]  in_cur_y,
  input  logic signed [pps_pkg::HEAD_W-1:0] in_cur_heading,
  input  logic signed [pps_pkg::POS_W-1:0]  in_goal_x,
  input  logic signed [pps_pkg::POS_W-1:0]  in_goal_y,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [pps_pkg::OUT_W-1:0]  out_lin_velocity,
  input  logic signed [pps_pkg::OUT_W-1:0]  out_turn_rate,
  input  logic signed [pps_pkg::OUT_W-1:0]  out_distance_error,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [pps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pps_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              wrap_up,
  output int                                fail_count,
  output int                                pending
);
  import pps_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] lin_velocity;
    logic signed [OUT_W-1:0] turn_rate;
    logic signed [OUT_W-1:0] distance_error;
  } steer_cmd_t;

  localparam longint ANGLE_PI   = 64'sd3373259426;
  localparam longint HEAD_PI    = 64'sd25736;
  localparam longint HEAD_2PI   = 64'sd51472;
  localparam longint INV_K_Q20  = 64'sd636751;
  localparam longint INTEG_MAX  = (64'sd1 <<< (INTEGRAL_WIDTH - 1)) - 64'sd1;
  localparam longint INTEG_MIN  = -INTEG_MAX - 64'sd1;
  localparam longint QUOT_CAP   = 64'sd1 <<< 40;

  steer_cmd_t cmd_expected[$];
  steer_cmd_t cmd_seen;
  steer_cmd_t cmd_want;
  logic       mode_q;
  longint     kp_q, ki_q, kh_q, lead_q;
  longint     vel_integral;
  logic       wrapped;

  // atan(2^-i) in Q2.30
  function automatic longint micro_angle(input int i);
    case (i)
      0:  return 64'sh3243F6A8;
      1:  return 64'sh1DAC6705;
      2:  return 64'sh0FADBAFC;
      3:  return 64'sh07F56EA6;
      4:  return 64'sh03FEAB76;
      5:  return 64'sh01FFD55B;
      6:  return 64'sh00FFFAAA;
      7:  return 64'sh007FFF55;
      8:  return 64'sh003FFFEA;
      9:  return 64'sh001FFFFD;
      10: return 64'sh000FFFFF;
      11: return 64'sh0007FFFF;
      12: return 64'sh0003FFFF;
      13: return 64'sh0001FFFF;
      14: return 64'sh0000FFFF;
      15: return 64'sh00007FFF;
      16: return 64'sh00003FFF;
      17: return 64'sh00001FFF;
      18: return 64'sh00000FFF;
      19: return 64'sh000007FF;
      20: return 64'sh000003FF;
      21: return 64'sh000001FF;
      22: return 64'sh000000FF;
      23: return 64'sh0000007F;
      24: return 64'sh0000003F;
      25: return 64'sh0000001F;
      26: return 64'sh0000000F;
      27: return 64'sh00000007;
      28: return 64'sh00000003;
      29: return 64'sh00000001;
      default: return 64'sd0;
    endcase
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Command for one pose/goal request; mode 0 also advances the velocity integral.
  task automatic predict_command(input logic signed [POS_W-1:0] cx, cy,
                                 input logic signed [HEAD_W-1:0] hd,
                                 input logic signed [POS_W-1:0] gx, gy,
                                 output steer_cmd_t cmd);
    longint dx, dy, hdg, xr, yr, zr, xs, ys;
    longint mag, bear, err, vel, quot, rem, diff, turn;
    longint unsigned scaled;
    int i;
    dx   = longint'(gx) - longint'(cx);
    dy   = longint'(gy) - longint'(cy);
    hdg  = longint'(hd);
    mag  = 0;
    bear = 0;
    if (dx != 0 || dy != 0) begin
      xr = dx <<< GUARD_BITS;
      yr = dy <<< GUARD_BITS;
      zr = 0;
      // fold the left half-plane onto the right one
      if (xr < 0) begin
        xr = -xr;
        yr = -yr;
        zr = (dy >= 0) ? ANGLE_PI : -ANGLE_PI;
      end
      for (i = 0; i < CORDIC_STEPS && i < 32; i++) begin
        xs = xr >>> i;
        ys = yr >>> i;
        if (yr >= 0) begin
          xr = xr + ys;
          yr = yr - xs;
          zr = zr + micro_angle(i);
        end else begin
          xr = xr - ys;
          yr = yr + xs;
          zr = zr - micro_angle(i);
        end
      end
      scaled = xr;
      scaled = (scaled * INV_K_Q20 + (64'd1 << (19 + GUARD_BITS))) >> (20 + GUARD_BITS);
      mag    = scaled;
      bear   = (zr + 64'sd65536) >>> 17;
    end

    if (mode_q == 1'b0) begin
      err = clamp32(mag - lead_q);
      if (err > 0 && vel_integral > INTEG_MAX - err) begin
        vel_integral = INTEG_MAX;
      end else if (err < 0 && vel_integral < INTEG_MIN - err) begin
        vel_integral = INTEG_MIN;
      end else begin
        vel_integral = vel_integral + err;
      end
      quot = vel_integral >>> 14;
      rem  = vel_integral - quot * 64'sd16384;
      if (quot > QUOT_CAP) quot = QUOT_CAP;
      if (quot < -QUOT_CAP) quot = -QUOT_CAP;
      vel = ki_q * quot + ((kp_q * err + ki_q * rem + 64'sd8192) >>> 14);
    end else begin
      err = clamp32(mag);
      vel = (kp_q * err + 64'sd8192) >>> 14;
    end
    vel = clamp32(vel);

    // a single wrap by a full turn
    diff = bear - hdg;
    if (diff > HEAD_PI) begin
      diff = diff - HEAD_2PI;
    end else if (diff < -HEAD_PI) begin
      diff = diff + HEAD_2PI;
    end
    turn = clamp32((kh_q * diff + 64'sd1024) >>> 11);

    cmd.lin_velocity   = vel[OUT_W-1:0];
    cmd.turn_rate      = turn[OUT_W-1:0];
    cmd.distance_error = err[OUT_W-1:0];
  endtask

  task automatic note_error(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count = fail_count + 1;
  endtask

  task automatic check_field(input string name, input logic signed [OUT_W-1:0] got, want);
    if (got !== want) note_error($sformatf("%s got %0d, want %0d", name, got, want));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q       = 1'b0;
      kp_q         = longint'(PROP_GAIN_RST);
      ki_q         = longint'(INTEGRAL_GAIN_RST);
      kh_q         = longint'(HEADING_GAIN_RST);
      lead_q       = 0;
      vel_integral = 0;
      wrapped      = 1'b0;
      cmd_expected.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (cmd_expected.size() == 0) begin
          note_error("command with no request outstanding");
        end else begin
          cmd_want = cmd_expected.pop_front();
          check_field("lin_velocity", out_lin_velocity, cmd_want.lin_velocity);
          check_field("turn_rate", out_turn_rate, cmd_want.turn_rate);
          check_field("distance_error", out_distance_error, cmd_want.distance_error);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE_SELECT:   mode_q = cfg_data[0];
          CFG_PROP_GAIN:     kp_q   = longint'(cfg_data[GAIN_W-1:0]);
          CFG_INTEGRAL_GAIN: ki_q   = longint'(cfg_data[GAIN_W-1:0]);
          CFG_HEADING_GAIN:  kh_q   = longint'(cfg_data[GAIN_W-1:0]);
          CFG_LEAD_DISTANCE: lead_q = longint'(cfg_data[LEAD_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_command(in_cur_x, in_cur_y, in_cur_heading, in_goal_x, in_goal_y, cmd_seen);
        cmd_expected.push_back(cmd_seen);
      end
      if (wrap_up && !wrapped) begin
        wrapped = 1'b1;
        if (cmd_expected.size() != 0)
          note_error($sformatf("%0d commands never arrived", cmd_expected.size()));
      end
    end
    pending = cmd_expected.size();
  end

endmodule

### sim/tb_top.sv
// Regression top for pure_pursuit_pi_steering_top: clock, reset, request and
// register-write stimulus, result back-pressure and the verdict.
// Depends on pps_pkg, the block under test and pps_checker.
module tb_top;
  import pps_pkg::*;

  localparam int CYCLE_LIMIT  = 1500000; // far beyond the slowest legal run
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1900;
  localparam int PHASES       = 8;

  localparam logic signed [POS_W-1:0]  POS_MAX  = 32'sh7FFFFFFF;
  localparam logic signed [POS_W-1:0]  POS_MIN  = 32'sh80000000;
  localparam logic signed [HEAD_W-1:0] HEAD_PI  = 16'sd25736;
  localparam logic [GAIN_W-1:0]        GAIN_TOP = 16'hFFFF;
  localparam logic [LEAD_W-1:0]        LEAD_TOP = 31'h7FFFFFFF;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                      in_valid;
  logic                      in_stall;
  logic signed [POS_W-1:0]   in_cur_x;
  logic signed [POS_W-1:0]   in_cur_y;
  logic signed [HEAD_W-1:0]  in_cur_heading;
  logic signed [POS_W-1:0]   in_goal_x;
  logic signed [POS_W-1:0]   in_goal_y;
  logic                      out_valid;
  logic                      out_stall;
  logic signed [OUT_W-1:0]   out_lin_velocity;
  logic signed [OUT_W-1:0]   out_turn_rate;
  logic signed [OUT_W-1:0]   out_distance_error;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_DATA_W-1:0]     cfg_data;

  logic wrap_up;
  logic quiet;      // when set, neither side idles
  int   fail_count;
  int   pending;
  int   cycles = 0;

  pure_pursuit_pi_steering_top u_top (.*);

  pps_checker u_checker (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("pure_pursuit_pi_steering_top regression: fail");
      $finish;
    end
  end

  // Idle length: mostly none, often a few cycles, now and then a long stretch.
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  // Result back-pressure: alternate open windows with random stalls.
  initial begin : stall_gen
    int run, hold;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      run = quiet ? 16 : $urandom_range(1, 10);
      out_stall = 1'b0;
      repeat (run) @(negedge clk);
      hold = quiet ? 0 : idle_len();
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
    end
  end

  // Present one request and hold it until the block takes it. Called at a
  // falling edge; returns at the falling edge after acceptance with valid
  // still high, so back-to-back requests never drop valid.
  task automatic send_pose(input logic signed [POS_W-1:0] cx, cy,
                           input logic signed [HEAD_W-1:0] hd,
                           input logic signed [POS_W-1:0] gx, gy);
    int gap;
    gap = quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_cur_x       = cx;
    in_cur_y       = cy;
    in_cur_heading = hd;
    in_goal_x      = gx;
    in_goal_y      = gy;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drop valid and wait until every outstanding command has come back.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Program all five registers, with junk in the unused data bits, then
  // hit an index past the last register, which the block must drop.
  task automatic apply_setting(input logic m, input logic [GAIN_W-1:0] kp, ki, kh,
                               input logic [LEAD_W-1:0] ld);
    logic [CFG_DATA_W-1:0] junk;
    logic [CFG_IDX_W-1:0]  spare;
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_MODE_SELECT, {junk[CFG_DATA_W-1:1], m});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_PROP_GAIN, {junk[CFG_DATA_W-1:GAIN_W], kp});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_INTEGRAL_GAIN, {junk[CFG_DATA_W-1:GAIN_W], ki});
    junk = CFG_DATA_W'($urandom);
    write_reg(CFG_HEADING_GAIN, {junk[CFG_DATA_W-1:GAIN_W], kh});
    write_reg(CFG_LEAD_DISTANCE, ld);
    spare = CFG_LEAD_DISTANCE + CFG_IDX_W'($urandom_range(1, 3));
    write_reg(spare, CFG_DATA_W'($urandom));
  endtask

  // Hand-picked poses: goal on the vehicle, full-range corners, each
  // half-plane fold, unit steps and headings at and past plus or minus pi.
  task automatic directed_pass();
    send_pose(32'sd0, 32'sd0, 16'sd0, 32'sd0, 32'sd0);
    send_pose(32'sh12345678, 32'shFEDCBA98, HEAD_PI, 32'sh12345678, 32'shFEDCBA98);
    send_pose(POS_MIN, POS_MIN, -HEAD_PI, POS_MAX, POS_MAX);
    send_pose(POS_MAX, POS_MIN, 16'sh7FFF, POS_MIN, POS_MAX);
    send_pose(POS_MAX, POS_MAX, 16'sh8000, POS_MIN, POS_MIN);
    send_pose(32'sd1, 32'sd0, -HEAD_PI, 32'sd0, 32'sd0);
    send_pose(32'sd0, 32'sd1, HEAD_PI, 32'sd0, 32'sd0);
    send_pose(32'sd0, 32'sd0, 16'sd0, 32'sd65536, 32'sd65536);
  endtask

  // Random request: the goal is anywhere, on the vehicle, straight along one
  // axis, or offset by a delta of random magnitude; heading mostly legal.
  task automatic random_pose();
    logic signed [POS_W-1:0]  cx, cy, gx, gy, ox, oy;
    logic signed [HEAD_W-1:0] hd;
    int kind;
    kind = $urandom_range(0, 9);
    cx = $urandom;
    cy = $urandom;
    ox = $urandom;
    oy = $urandom;
    ox = ox >>> $urandom_range(0, 31);
    oy = oy >>> $urandom_range(0, 31);
    case (kind)
      0, 1: begin
        gx = $urandom;
        gy = $urandom;
      end
      2: begin
        gx = cx;
        gy = cy;
      end
      3: begin
        gx = cx;
        gy = cy + oy;
      end
      4: begin
        gx = cx + ox;
        gy = cy;
      end
      default: begin
        gx = cx + ox;
        gy = cy + oy;
      end
    endcase
    if ($urandom_range(0, 9) == 0) begin
      hd = HEAD_W'($urandom);
    end else begin
      hd = HEAD_W'(int'($urandom_range(0, 2 * PI_Q13)) - PI_Q13);
    end
    send_pose(cx, cy, hd, gx, gy);
  endtask

  // Pick the register setting of one random phase; the first few are
  // corners of the setting space or the reset gains, the rest are random.
  task automatic phase_setting(input int ph);
    logic [LEAD_W-1:0] ld;
    ld = LEAD_W'($urandom);
    ld = ld >> $urandom_range(1, 30);
    case (ph)
      0: apply_setting(1'b0, '0, '0, '0, '0);
      1: apply_setting(1'b0, GAIN_TOP, GAIN_TOP, GAIN_TOP, '0);
      2: apply_setting(1'b1, GAIN_TOP, GAIN_W'($urandom), GAIN_TOP, LEAD_TOP);
      3: apply_setting(1'b1, '0, '0, '0, ld);
      4: apply_setting(1'b0, PROP_GAIN_RST, INTEGRAL_GAIN_RST, HEADING_GAIN_RST, ld);
      default: apply_setting(1'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                             GAIN_W'($urandom), ld);
    endcase
  endtask

  initial begin : main_seq
    int ph, n;
    in_valid       = 1'b0;
    in_cur_x       = '0;
    in_cur_y       = '0;
    in_cur_heading = '0;
    in_goal_x      = '0;
    in_goal_y      = '0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_MODE_SELECT;
    cfg_data       = '0;
    wrap_up        = 1'b0;
    quiet          = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Directed poses under the reset setting, then with the largest lead
    // (negative error but at the full-range corners), then in proportional mode.
    directed_pass();
    wait_idle();
    apply_setting(1'b0, GAIN_TOP, GAIN_TOP, GAIN_TOP, LEAD_TOP);
    directed_pass();
    wait_idle();
    apply_setting(1'b1, GAIN_TOP, '0, GAIN_TOP, '0);
    directed_pass();

    // Random phases; the integral carries over between them, mode changes
    // included. Every so often run a stretch with no idling on either side.
    for (ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      phase_setting(ph);
      for (n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        if (n % 40 == 0) quiet = ($urandom_range(0, 4) == 0);
        random_pose();
      end
    end

    wait_idle();
    quiet = 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    wrap_up = 1'b1;
    @(negedge clk);
    if (fail_count == 0) begin
      $display("pure_pursuit_pi_steering_top regression: pass");
    end else begin
      $display("pure_pursuit_pi_steering_top regression: fail");
    end
    $finish;
  end

endmodule
